// ===== src/cbs_pkg.sv =====
package cbs_pkg;

  localparam int CELLS   = 6;
  localparam int MV_W    = 13;
  localparam int IDX_W   = 3;
  localparam int MS_W    = 16;
  localparam int TEMP_W  = 8;
  localparam int ACC_W   = 32;
  localparam int MASK_W  = 6;

  // in_tdata layout, lowest bit first
  localparam int ELAPSED_LSB = 0;
  localparam int CELL_LSB    = ELAPSED_LSB + MS_W;
  localparam int TCELL_LSB   = CELL_LSB + CELLS * MV_W;
  localparam int TCHIP_LSB   = TCELL_LSB + TEMP_W;
  localparam int FAULT_BIT   = TCHIP_LSB + TEMP_W;
  localparam int IN_BITS     = FAULT_BIT + 1;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((MASK_W + 7) / 8) * 8;
  localparam int CFG_DATA_W  = 16;

  typedef logic [MV_W-1:0]   mv_t;
  typedef logic [IDX_W-1:0]  cell_idx_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam cell_idx_t NO_CELL = IDX_W'(CELLS);

  typedef enum logic [2:0] {
    REG_PERIOD      = 3'd0,
    REG_START_MIN   = 3'd1,
    REG_STOP_MIN    = 3'd2,
    REG_START_DELTA = 3'd3,
    REG_STOP_DELTA  = 3'd4,
    REG_TCELL_LOW   = 3'd5,
    REG_TCELL_HIGH  = 3'd6,
    REG_TCHIP_LIMIT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [MS_W-1:0]          period_ms;
    mv_t                      start_min_mv;
    mv_t                      stop_min_mv;
    mv_t                      start_delta_mv;
    mv_t                      stop_delta_mv;
    logic signed [TEMP_W-1:0] tcell_low_c;
    logic signed [TEMP_W-1:0] tcell_high_c;
    logic signed [TEMP_W-1:0] tchip_limit_c;
  } cfg_t;

endpackage

// ===== src/cell_balance_selector_core.sv =====
// An accepted input item is registered in stage 1; its result is then registered behind out_tvalid.
// Throughput: one item per cycle while the result side is not stalled; a tick below the period gives no result.
// The accumulator, last cell and decision logic sit between the two registers.
// Reset (rst_n low, synchronous): pipeline emptied, accumulator cleared, no last cell,
// configuration registers back to their default values.
module cell_balance_selector_core
  import cbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // elapsed_ms, cell0_mv..cell5_mv, cell_temp_c, chip_temp_c, any_fault, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // sample valid flag
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bleed mask, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                     cfg_r;

  logic                     s1_vld_r;
  logic [MS_W-1:0]          s1_elapsed_r;
  mv_t                      s1_cells_r [CELLS];
  logic signed [TEMP_W-1:0] s1_tcell_r;
  logic signed [TEMP_W-1:0] s1_tchip_r;
  logic                     s1_fault_r;
  logic                     s1_valid_r;

  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         acc_sat;
  logic [ACC_W:0]           acc_sum;
  cell_idx_t                last_cell_r;
  cell_idx_t                pick_idx;
  logic                     decide;
  logic                     adv;

  logic                     out_vld_r;
  mask_t                    out_mask_r;
  mask_t                    mask_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ms      <= MS_W'(1000);
      cfg_r.start_min_mv   <= MV_W'(3900);
      cfg_r.stop_min_mv    <= MV_W'(3850);
      cfg_r.start_delta_mv <= MV_W'(40);
      cfg_r.stop_delta_mv  <= MV_W'(20);
      cfg_r.tcell_low_c    <= TEMP_W'(0);
      cfg_r.tcell_high_c   <= TEMP_W'(45);
      cfg_r.tchip_limit_c  <= TEMP_W'(70);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PERIOD:      cfg_r.period_ms      <= cfg_data;
        REG_START_MIN:   cfg_r.start_min_mv   <= cfg_data[MV_W-1:0];
        REG_STOP_MIN:    cfg_r.stop_min_mv    <= cfg_data[MV_W-1:0];
        REG_START_DELTA: cfg_r.start_delta_mv <= cfg_data[MV_W-1:0];
        REG_STOP_DELTA:  cfg_r.stop_delta_mv  <= cfg_data[MV_W-1:0];
        REG_TCELL_LOW:   cfg_r.tcell_low_c    <= cfg_data[TEMP_W-1:0];
        REG_TCELL_HIGH:  cfg_r.tcell_high_c   <= cfg_data[TEMP_W-1:0];
        REG_TCHIP_LIMIT: cfg_r.tchip_limit_c  <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 moves on whenever the result register is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_elapsed_r <= in_tdata[ELAPSED_LSB +: MS_W];
      for (int i = 0; i < CELLS; i++) begin
        s1_cells_r[i] <= in_tdata[CELL_LSB + i*MV_W +: MV_W];
      end
      s1_tcell_r <= in_tdata[TCELL_LSB +: TEMP_W];
      s1_tchip_r <= in_tdata[TCHIP_LSB +: TEMP_W];
      s1_fault_r <= in_tdata[FAULT_BIT];
      s1_valid_r <= in_tuser;
    end
  end

  assign acc_sum = {1'b0, acc_r} + {{(ACC_W+1-MS_W){1'b0}}, s1_elapsed_r};
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  assign decide  = (acc_sat >= {{(ACC_W-MS_W){1'b0}}, cfg_r.period_ms}) || s1_fault_r;
  assign acc_nxt = decide ? '0 : acc_sat;

  cbs_select u_select (
    .cells     (s1_cells_r),
    .tcell_c   (s1_tcell_r),
    .tchip_c   (s1_tchip_r),
    .fault     (s1_fault_r),
    .valid     (s1_valid_r),
    .cfg       (cfg_r),
    .last_cell (last_cell_r),
    .pick_idx  (pick_idx)
  );

  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (pick_idx == IDX_W'(i)) begin
        mask_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      last_cell_r <= NO_CELL;
      out_vld_r   <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r && decide;
      if (s1_vld_r) begin
        acc_r <= acc_nxt;
        if (decide) begin
          last_cell_r <= pick_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r && decide) begin
      out_mask_r <= mask_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-MASK_W){1'b0}}, out_mask_r};

endmodule

// ===== src/cbs_select.sv =====
module cbs_select
  import cbs_pkg::*;
(
  input  mv_t                      cells [CELLS],
  input  logic signed [TEMP_W-1:0] tcell_c,
  input  logic signed [TEMP_W-1:0] tchip_c,
  input  logic                     fault,
  input  logic                     valid,
  input  cfg_t                     cfg,
  input  cell_idx_t                last_cell,
  output cell_idx_t                pick_idx
);

  mv_t       mn;
  mv_t       mx;
  mv_t       spread;
  mv_t       last_mv;
  mv_t       last_excess;
  cell_idx_t max_idx;
  logic      last_ok;

  always_comb begin
    mn      = cells[0];
    mx      = cells[0];
    max_idx = '0;
    for (int i = 1; i < CELLS; i++) begin
      if (cells[i] < mn) begin
        mn = cells[i];
      end
      // strict compare keeps the lowest index on a tie
      if (cells[i] > mx) begin
        mx      = cells[i];
        max_idx = IDX_W'(i);
      end
    end
  end

  assign spread = mx - mn;

  always_comb begin
    last_mv = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (last_cell == IDX_W'(i)) begin
        last_mv = cells[i];
      end
    end
  end

  assign last_ok     = (last_cell < NO_CELL);
  assign last_excess = last_mv - mn;

  always_comb begin
    priority if (fault || !valid) begin
      pick_idx = NO_CELL;
    end else if (tcell_c < cfg.tcell_low_c || tcell_c > cfg.tcell_high_c ||
                 tchip_c >= cfg.tchip_limit_c) begin
      pick_idx = NO_CELL;
    end else if (mn < cfg.stop_min_mv || spread <= cfg.stop_delta_mv) begin
      pick_idx = NO_CELL;
    end else if (mn < cfg.start_min_mv || spread < cfg.start_delta_mv) begin
      // hysteresis band: hold the previous cell while it is still high enough
      pick_idx = (last_ok && last_excess > cfg.stop_delta_mv) ? last_cell : NO_CELL;
    end else begin
      pick_idx = max_idx;
    end
  end

endmodule

// ===== src/cbs_checker.sv =====
module cbs_checker
  import cbs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // never more than one cell bleeding
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[MASK_W-1:0]))
    else $error("more than one cell selected");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:MASK_W] == '0)
    else $error("pad bits of result set");

  // no result can appear in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the result side free, the input side cannot be stalled
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind cell_balance_selector_core cbs_checker u_cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/cell_balance_selector_core_test.sv =====
`timescale 1ns / 1ps

module cell_balance_selector_core_test;
  import cbs_pkg::*;

  typedef struct packed {
    logic [MS_W-1:0]          elapsed;
    mv_t [CELLS-1:0]          mv;
    logic signed [TEMP_W-1:0] tcell;
    logic signed [TEMP_W-1:0] tchip;
    logic                     fault;
    logic                     valid;
  } tick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // elapsed_ms, cell0_mv..cell5_mv, cell_temp_c, chip_temp_c, any_fault, zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // sample valid flag
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // bleed mask, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state and its copy of the thresholds
  logic [ACC_W-1:0] accum_ms    = '0;
  int               last_pick   = CELLS;
  logic [MS_W-1:0]  period_ms   = 16'd1000;
  int               start_min   = 3900;
  int               stop_min    = 3850;
  int               start_delta = 40;
  int               stop_delta  = 20;
  int               tcell_low   = 0;
  int               tcell_high  = 45;
  int               tchip_limit = 70;

  mask_t expected_masks[$];
  tick_t tick_on_bus;
  int    fail_count     = 0;
  int    in_gap_pct     = 0;
  int    rx_stall_pct   = 0;
  int    rx_hold_cycles = 0;

  // slowly drifting pack used for well-formed traffic
  int pack_base = 3950;
  int cell_ofs[CELLS];

  cell_balance_selector_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_cell(input tick_t t);
    int mn;
    int mx;
    int max_idx;
    int spread;
    if (t.fault || !t.valid) return CELLS;
    if ($signed(t.tcell) < tcell_low || $signed(t.tcell) > tcell_high ||
        $signed(t.tchip) >= tchip_limit)
      return CELLS;
    mn = int'(t.mv[0]);
    mx = mn;
    max_idx = 0;
    for (int i = 1; i < CELLS; i++) begin
      if (int'(t.mv[i]) < mn) mn = int'(t.mv[i]);
      if (int'(t.mv[i]) > mx) begin
        mx = int'(t.mv[i]);
        max_idx = i;
      end
    end
    spread = mx - mn;
    if (mn < stop_min || spread <= stop_delta) return CELLS;
    // hysteresis band: keep the previous cell while it is still high enough
    if (mn < start_min || spread < start_delta) begin
      if (last_pick < CELLS && int'(t.mv[last_pick]) - mn > stop_delta) return last_pick;
      return CELLS;
    end
    return max_idx;
  endfunction

  function automatic bit predict_tick(input tick_t t, output mask_t mask);
    logic [ACC_W:0] sum;
    int pick;
    sum = {1'b0, accum_ms} + (ACC_W+1)'(t.elapsed);
    accum_ms = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    mask = '0;
    if (accum_ms < period_ms && !t.fault) return 1'b0;
    accum_ms = '0;
    pick = pick_cell(t);
    last_pick = pick;
    if (pick < CELLS) mask = mask_t'(1) << pick;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    mask_t m;
    if (rst_n && in_tvalid && in_tready) begin
      if (predict_tick(tick_on_bus, m)) expected_masks.push_back(m);
    end
  end

  always @(posedge clk) begin
    mask_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_masks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = expected_masks.pop_front();
        if (out_tdata !== OUT_DATA_W'(want)) begin
          $display("%0t: bleed mask mismatch, expected %h, actual %h",
                   $time, OUT_DATA_W'(want), out_tdata);
          fail_count++;
        end
      end
    end
  end

  // result side: random stall, or a counted hold-off when asked for
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  function automatic tick_t mk_tick(int el, int c0, int c1, int c2, int c3, int c4, int c5,
                                    int tc = 25, int tp = 40, bit flt = 0, bit ok = 1);
    tick_t t;
    t.elapsed = MS_W'(el);
    t.mv      = {mv_t'(c5), mv_t'(c4), mv_t'(c3), mv_t'(c2), mv_t'(c1), mv_t'(c0)};
    t.tcell   = TEMP_W'(tc);
    t.tchip   = TEMP_W'(tp);
    t.fault   = flt;
    t.valid   = ok;
    return t;
  endfunction

  function automatic tick_t random_tick(int noise_pct);
    tick_t t;
    logic [127:0] raw;
    int el_max;
    if ($urandom_range(0, 99) < noise_pct) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(tick_t)-1:0];
    end
    pack_base += int'($urandom_range(0, 16)) - 8;
    if (pack_base < 3750) pack_base = 3750;
    if (pack_base > 4150) pack_base = 4150;
    if ($urandom_range(0, 9) == 0) cell_ofs[$urandom_range(0, CELLS-1)] = $urandom_range(0, 120);
    for (int i = 0; i < CELLS; i++) begin
      cell_ofs[i] += int'($urandom_range(0, 8)) - 4;
      if (cell_ofs[i] < 0) cell_ofs[i] = 0;
      if (cell_ofs[i] > 120) cell_ofs[i] = 120;
      t.mv[i] = mv_t'(pack_base + cell_ofs[i]);
    end
    t.tcell = TEMP_W'(int'($urandom_range(0, 70)) - 10);
    t.tchip = TEMP_W'(int'($urandom_range(0, 99)) - 10);
    t.fault = ($urandom_range(0, 99) < 4);
    t.valid = ($urandom_range(0, 99) >= 3);
    el_max = (period_ms == 0) ? 50 : 2 * int'(period_ms);
    if (el_max > 65535) el_max = 65535;
    t.elapsed = MS_W'($urandom_range(0, el_max));
    return t;
  endfunction

  // entered anywhere; returns at the rising edge where the item was taken
  task automatic send_tick(input tick_t t);
    logic [IN_DATA_W-1:0] bus;
    bus = '0;
    bus[ELAPSED_LSB +: MS_W] = t.elapsed;
    for (int i = 0; i < CELLS; i++) bus[CELL_LSB + i*MV_W +: MV_W] = t.mv[i];
    bus[TCELL_LSB +: TEMP_W] = t.tcell;
    bus[TCHIP_LSB +: TEMP_W] = t.tchip;
    bus[FAULT_BIT] = t.fault;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= bus;
    in_tuser    <= t.valid;
    tick_on_bus <= t;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    // ticks below the period leave no trace in the result stream
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    logic [CFG_DATA_W-1:0] word;
    case (idx)
      REG_PERIOD: word = CFG_DATA_W'(val & 'hFFFF);
      REG_TCELL_LOW, REG_TCELL_HIGH, REG_TCHIP_LIMIT: word = CFG_DATA_W'(val & 'hFF);
      default: word = CFG_DATA_W'(val & 'h1FFF);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PERIOD:      period_ms   = word;
      REG_START_MIN:   start_min   = int'(word);
      REG_STOP_MIN:    stop_min    = int'(word);
      REG_START_DELTA: start_delta = int'(word);
      REG_STOP_DELTA:  stop_delta  = int'(word);
      REG_TCELL_LOW:   tcell_low   = int'($signed(word[7:0]));
      REG_TCELL_HIGH:  tcell_high  = int'($signed(word[7:0]));
      REG_TCHIP_LIMIT: tchip_limit = int'($signed(word[7:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_thresholds(int per, int smin, int pmin, int sdel, int pdel,
                                 int tlo, int thi, int tlim);
    write_reg(REG_PERIOD, per);
    write_reg(REG_START_MIN, smin);
    write_reg(REG_STOP_MIN, pmin);
    write_reg(REG_START_DELTA, sdel);
    write_reg(REG_STOP_DELTA, pdel);
    write_reg(REG_TCELL_LOW, tlo);
    write_reg(REG_TCELL_HIGH, thi);
    write_reg(REG_TCHIP_LIMIT, tlim);
  endtask

  task automatic load_random_thresholds();
    int smin;
    int sdel;
    int per;
    smin = 3800 + $urandom_range(0, 250);
    sdel = $urandom_range(5, 100);
    case ($urandom_range(0, 3))
      0: per = 0;
      1: per = $urandom_range(1, 20);
      2: per = $urandom_range(20, 2000);
      default: per = 1000;
    endcase
    load_thresholds(per, smin, smin - int'($urandom_range(0, 100)), sdel,
                    $urandom_range(0, sdel), -int'($urandom_range(0, 20)),
                    30 + $urandom_range(0, 30), 50 + $urandom_range(0, 40));
  endtask

  // reset thresholds: period 1000, start 3900/40, stop 3850/20, window 0..45, chip < 70
  task automatic test_default_thresholds();
    send_tick(mk_tick(999, 3950, 3960, 3970, 3980, 3990, 4000));
    send_tick(mk_tick(1, 3950, 3960, 3970, 3980, 3990, 4000));
    send_tick(mk_tick(1000, 3950, 3950, 3950, 3950, 3950, 3980));   // held
    send_tick(mk_tick(1000, 3950, 3950, 3980, 3950, 3950, 3965));   // held cell too low
    send_tick(mk_tick(1000, 3950, 3990, 3990, 3950, 3950, 3950));   // tie
    send_tick(mk_tick(1000, 3880, 3990, 3950, 3950, 3950, 3950));   // min in band
    send_tick(mk_tick(1000, 3849, 4000, 3950, 3950, 3950, 3950));
    send_tick(mk_tick(1000, 3950, 3970, 3950, 3950, 3950, 3950));   // spread at stop
    send_tick(mk_tick(500, 3950, 3960, 3970, 3980, 3990, 4000));
    send_tick(mk_tick(0, 3950, 3960, 3970, 3980, 3990, 4000, 25, 40, 1, 1));
    send_tick(mk_tick(999, 3950, 3960, 3970, 3980, 3990, 4000));
    send_tick(mk_tick(1, 3950, 3960, 3970, 3980, 3990, 4000));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 25, 40, 0, 0));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, -1, 40));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 0, 40));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 45, 40));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 46, 40));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 25, 69));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 25, 70));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, -128, -128));
    send_tick(mk_tick(1000, 3950, 3960, 3970, 3980, 3990, 4000, 127, 127));
    send_tick(mk_tick(65535, 8191, 8191, 8191, 8191, 8191, 8191));
    send_tick(mk_tick(65535, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(65535, 0, 8191, 0, 8191, 0, 8191));
    send_tick(mk_tick(65535, 8100, 8191, 8150, 8120, 8191, 8100));
    wait_all_results();
  endtask

  task automatic test_register_extremes();
    // everything open, a decision every tick
    load_thresholds(0, 0, 0, 0, 0, -128, 127, 127);
    for (int n = 0; n < 25; n++) send_tick(random_tick(100));
    wait_all_results();
    // everything closed, longest period
    load_thresholds(65535, 8191, 8191, 8191, 8191, 127, -128, -128);
    for (int n = 0; n < 10; n++) begin
      send_tick(mk_tick(65535, $urandom_range(0, 8191), $urandom_range(0, 8191),
                        $urandom_range(0, 8191), $urandom_range(0, 8191),
                        $urandom_range(0, 8191), $urandom_range(0, 8191)));
      send_tick(random_tick(100));
    end
    wait_all_results();
    // start thresholds below the stop thresholds
    load_thresholds(1, 3800, 3900, 20, 50, 0, 45, 70);
    for (int n = 0; n < 40; n++) send_tick(random_tick(5));
    wait_all_results();
  endtask

  task automatic test_output_stall();
    in_gap_pct   = 0;
    rx_stall_pct = 0;
    load_thresholds(0, 3900, 3850, 40, 20, 0, 45, 70);
    rx_hold_cycles = 300;
    for (int n = 0; n < 40; n++) send_tick(random_tick(0));
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin in_gap_pct = 59; rx_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  rx_stall_pct = 59; end
        default: begin in_gap_pct = 29; rx_stall_pct = 29; end
      endcase
      for (int c = 0; c < 3; c++) begin
        load_random_thresholds();
        for (int n = 0; n < 100; n++) begin
          send_tick(random_tick(8));
          if (n == 50 && $urandom_range(0, 1) == 1) wait_all_results();
        end
        wait_all_results();
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    tick_on_bus = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_PERIOD;
    cfg_data    = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_thresholds();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();

    wait_all_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_masks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
